// ===== hw/rtl/nkc_pkg.sv =====
package nkc_pkg;

  // Keyword geometry
  localparam int MAX_KEY  = 32;
  localparam int KEY_W    = 6;
  localparam int GAP_W    = 6;
  localparam int COUNT_W  = 32;
  localparam int APB_AW   = 6;
  localparam int APB_DW   = 64;
  localparam int REG_IDXW = 3;

  localparam logic [GAP_W-1:0]   GAP_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [KEY_W-1:0]   KEY_MAX   = KEY_W'(MAX_KEY);

  // Register map, index = paddr[5:3]
  localparam logic [REG_IDXW-1:0] REG_KEY_LEN   = 3'd0;
  localparam logic [REG_IDXW-1:0] REG_KEY_WORD0 = 3'd1;
  localparam logic [REG_IDXW-1:0] REG_KEY_WORD1 = 3'd2;
  localparam logic [REG_IDXW-1:0] REG_KEY_WORD2 = 3'd3;
  localparam logic [REG_IDXW-1:0] REG_KEY_WORD3 = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic               match_end;
    logic [COUNT_W-1:0] match_count;
    logic               text_done;
  } out_t;

  // Keyword as seen by the window: entry j of the window must equal rkey[j]
  // wherever mask[j] is set.
  typedef struct packed {
    logic [KEY_W-1:0]            len;
    logic [MAX_KEY-1:0]          mask;
    logic [MAX_KEY-1:0][7:0]     rkey;
  } key_cfg_t;

endpackage

// ===== hw/rtl/nonoverlap_keyword_counter_core.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      in_data  (text_byte, end_of_text)
// out      output     out_valid / out_ready    out_data (match_end, match_count, text_done)
// cfg      input      APB psel/penable/pwrite  paddr, pwdata, prdata (64-bit registers)
//
// One item per cycle sustained while the output is not stalled; each result passes through
// the input register, then the compare and count into the result register.
// The key is re-aligned into a register in the cycle after each register write.
// rst is synchronous: clears the window, gap, count, and both stage valids.
// A stalled result holds the result register; the input register still takes an
// item while it is empty, or while the result register is free or being drained.
module nonoverlap_keyword_counter_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nkc_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output nkc_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nkc_pkg::APB_AW-1:0] paddr,
  input  logic [nkc_pkg::APB_DW-1:0] pwdata,
  output logic [nkc_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  nkc_pkg::key_cfg_t kcfg;
  nkc_pkg::in_t      s1_item;
  nkc_pkg::out_t     res;
  logic              s1_valid;
  logic              adv;

  nkc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .kcfg    (kcfg)
  );

  nkc_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .item (s1_item),
    .kcfg (kcfg),
    .res  (res)
  );

  // Pipeline control
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

  // A held item in the input register blocks new items
  a_s1_block: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |-> !in_ready)
    else $error("input taken while stage 1 is stalled");

  // An advanced item always lands in the result register
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("advanced item lost");

  // A stalled result never gets overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !adv)
    else $error("result overwritten while stalled");

endmodule

// ===== hw/rtl/nkc_cfg.sv =====
module nkc_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nkc_pkg::APB_AW-1:0] paddr,
  input  logic [nkc_pkg::APB_DW-1:0] pwdata,
  output logic [nkc_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output nkc_pkg::key_cfg_t          kcfg
);

  logic [nkc_pkg::KEY_W-1:0]   key_len;
  logic [nkc_pkg::APB_DW-1:0]  key_word [4];
  logic [nkc_pkg::REG_IDXW-1:0] reg_idx;
  logic                        wr_en;

  logic [nkc_pkg::MAX_KEY*8-1:0] key_flat;
  logic [nkc_pkg::KEY_W-1:0]     len_eff;
  logic [nkc_pkg::KEY_W-1:0]     kidx [nkc_pkg::MAX_KEY];
  nkc_pkg::key_cfg_t             kcfg_next;

  assign reg_idx = paddr[nkc_pkg::APB_AW-1:nkc_pkg::APB_AW-nkc_pkg::REG_IDXW];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_len     <= nkc_pkg::KEY_W'(1);
      key_word[0] <= '0;
      key_word[1] <= '0;
      key_word[2] <= '0;
      key_word[3] <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        nkc_pkg::REG_KEY_LEN:   key_len     <= pwdata[nkc_pkg::KEY_W-1:0];
        nkc_pkg::REG_KEY_WORD0: key_word[0] <= pwdata;
        nkc_pkg::REG_KEY_WORD1: key_word[1] <= pwdata;
        nkc_pkg::REG_KEY_WORD2: key_word[2] <= pwdata;
        nkc_pkg::REG_KEY_WORD3: key_word[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      nkc_pkg::REG_KEY_LEN:   prdata = nkc_pkg::APB_DW'(key_len);
      nkc_pkg::REG_KEY_WORD0: prdata = key_word[0];
      nkc_pkg::REG_KEY_WORD1: prdata = key_word[1];
      nkc_pkg::REG_KEY_WORD2: prdata = key_word[2];
      nkc_pkg::REG_KEY_WORD3: prdata = key_word[3];
      default:                prdata = '0;
    endcase
  end

  // Keyword reversed into window order; overlong lengths clamp to the window
  assign key_flat = {key_word[3], key_word[2], key_word[1], key_word[0]};
  assign len_eff  = (key_len > nkc_pkg::KEY_MAX) ? nkc_pkg::KEY_MAX : key_len;

  always_comb begin
    kcfg_next.len = len_eff;
    for (int j = 0; j < nkc_pkg::MAX_KEY; j++) begin
      kidx[j] = nkc_pkg::KEY_W'(len_eff - nkc_pkg::KEY_W'(j) - nkc_pkg::KEY_W'(1));
      kcfg_next.mask[j] = (nkc_pkg::KEY_W'(j) < len_eff);
      kcfg_next.rkey[j] = kcfg_next.mask[j] ? key_flat[kidx[j][4:0]*8 +: 8] : 8'h00;
    end
  end

  // Registered so the wide mux stays off the datapath
  always_ff @(posedge clk) begin
    kcfg <= kcfg_next;
  end

endmodule

// ===== hw/rtl/nkc_scan.sv =====
module nkc_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  nkc_pkg::in_t      item,
  input  nkc_pkg::key_cfg_t kcfg,
  output nkc_pkg::out_t     res
);

  logic [7:0]                  window      [nkc_pkg::MAX_KEY];
  logic [7:0]                  window_next [nkc_pkg::MAX_KEY];
  logic [nkc_pkg::GAP_W-1:0]   gap;
  logic [nkc_pkg::GAP_W-1:0]   gap_now;
  logic [nkc_pkg::GAP_W-1:0]   gap_next;
  logic [nkc_pkg::COUNT_W-1:0] count;
  logic [nkc_pkg::COUNT_W-1:0] count_next;
  logic [nkc_pkg::MAX_KEY-1:0] byte_ok;
  logic                        hit;

  // Window after shifting in the new byte, entry 0 newest
  always_comb begin
    window_next[0] = item.text_byte;
    for (int j = 1; j < nkc_pkg::MAX_KEY; j++) begin
      window_next[j] = window[j-1];
    end
  end

  // Masked parallel compare
  always_comb begin
    for (int j = 0; j < nkc_pkg::MAX_KEY; j++) begin
      byte_ok[j] = !kcfg.mask[j] || (window_next[j] == kcfg.rkey[j]);
    end
  end

  assign gap_now = (gap == nkc_pkg::GAP_MAX) ? gap : gap + nkc_pkg::GAP_W'(1);
  assign hit     = (kcfg.len != '0) && (gap_now >= kcfg.len) && (&byte_ok);

  assign count_next = (hit && count != nkc_pkg::COUNT_MAX) ?
                      count + nkc_pkg::COUNT_W'(1) : count;
  assign gap_next   = hit ? '0 : gap_now;

  assign res.match_end   = hit;
  assign res.match_count = count_next;
  assign res.text_done   = item.end_of_text;

  // State update; end of text clears after reporting
  always_ff @(posedge clk) begin
    if (rst) begin
      gap   <= '0;
      count <= '0;
      for (int j = 0; j < nkc_pkg::MAX_KEY; j++) window[j] <= 8'h00;
    end else if (adv) begin
      if (item.end_of_text) begin
        gap   <= '0;
        count <= '0;
        for (int j = 0; j < nkc_pkg::MAX_KEY; j++) window[j] <= 8'h00;
      end else begin
        gap   <= gap_next;
        count <= count_next;
        for (int j = 0; j < nkc_pkg::MAX_KEY; j++) window[j] <= window_next[j];
      end
    end
  end

  // End of text leaves a clean state
  a_eot_clear: assert property (@(posedge clk) disable iff (rst)
    adv && item.end_of_text |=> count == '0 && gap == '0 && window[0] == 8'h00)
    else $error("state not cleared after end of text");

  // A counted match always reports a nonzero count
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    hit |-> res.match_count != '0)
    else $error("match reported with zero count");

  // Count only moves on a counted match
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    adv && !hit && !item.end_of_text |=> count == $past(count))
    else $error("count changed without a match");

  // Gap resets after a counted match
  a_gap_reset: assert property (@(posedge clk) disable iff (rst)
    adv && hit |=> gap == '0)
    else $error("gap not reset after match");

endmodule
